FILE: src/swarq_pkg.sv
// Shared types and codes for the go-back-N sender window.
package swarq_pkg;

	// Operation selector carried with each input beat.
	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_FETCH = 3'd1,
		FN_ACK   = 3'd2,
		FN_NAK   = 3'd3,
		FN_CLEAR = 3'd4
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOTHING = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_EXEC = 1'b1
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted input beat
		logic commit;  // execute the captured operation and load the result
	} ctrl_cmd_t;

	localparam int unsigned InDataW  = 16;
	localparam int unsigned InUserW  = 3;
	localparam int unsigned OutDataW = 16;
	localparam int unsigned OutUserW = 3;

endpackage

FILE: src/swarq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module swarq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: src/swarq_ctrl.sv
// Controller state machine: input and output handshakes and datapath sequencing.
module swarq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output swarq_pkg::ctrl_cmd_t cmd
);
	import swarq_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;
	logic        out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		out_free    = !out_valid_q || out_ready;
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = CS_EXEC;
				end
			end
			CS_EXEC: begin
				// The result may only be committed once the output register is free.
				if (out_free) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

FILE: src/swarq_dpath.sv
// Datapath: window pointers, flags, character store and result register.
module swarq_dpath #(
	parameter int unsigned WINDOW = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swarq_pkg::ctrl_cmd_t              cmd,
	input  logic [swarq_pkg::InDataW-1:0]     in_data,
	input  logic [swarq_pkg::InUserW-1:0]     in_user,
	output logic [swarq_pkg::OutDataW-1:0]    out_data,
	output logic [swarq_pkg::OutUserW-1:0]    out_user
);
	import swarq_pkg::*;

	localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CW = (PW > 3) ? PW : 3;
	localparam logic [PW-1:0] LastPtr = PW'(WINDOW - 1);

	// Captured input beat.
	func_t      func_q;
	logic [7:0] char_q;
	logic [2:0] num_q;

	// Window state.
	logic [PW-1:0]     wr_ptr_q, snd_ptr_q, ack_ptr_q;
	logic [PW-1:0]     wr_ptr_d, snd_ptr_d, ack_ptr_d;
	logic              full_q, empty_q, full_d, empty_d;
	logic [WINDOW-1:0] vld_q, vld_d;

	// Result register.
	status_t    status_q, status_d;
	logic       fvalid_q, fvalid_d;
	logic [7:0] fchar_q, fchar_d;
	logic [2:0] snum_q, snum_d, anum_q, anum_d;

	logic [7:0]    rd_data;
	logic          ram_we;
	logic [PW-1:0] wr_next, wr_next2, snd_next, ack_next;
	logic [CW-1:0] num_w, snd_w, ack_w;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		ring_next = (p == LastPtr) ? '0 : p + PW'(1);
	endfunction

	swarq_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (char_q),
		.raddr (snd_ptr_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_user[2:0]);
			char_q <= in_data[7:0];
			num_q  <= in_data[10:8];
		end
		if (cmd.commit) begin
			status_q <= status_d;
			fvalid_q <= fvalid_d;
			fchar_q  <= fchar_d;
			snum_q   <= snum_d;
			anum_q   <= anum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			snd_ptr_q <= '0;
			ack_ptr_q <= '0;
			full_q    <= 1'b0;
			empty_q   <= 1'b1;
			vld_q     <= '0;
		end else if (cmd.commit) begin
			wr_ptr_q  <= wr_ptr_d;
			snd_ptr_q <= snd_ptr_d;
			ack_ptr_q <= ack_ptr_d;
			full_q    <= full_d;
			empty_q   <= empty_d;
			vld_q     <= vld_d;
		end
	end

	always_comb begin
		wr_next  = ring_next(wr_ptr_q);
		wr_next2 = ring_next(wr_next);
		snd_next = ring_next(snd_ptr_q);
		ack_next = ring_next(ack_ptr_q);
		num_w    = CW'(num_q);
		snd_w    = CW'(snd_ptr_q);
		ack_w    = CW'(ack_ptr_q);

		wr_ptr_d  = wr_ptr_q;
		snd_ptr_d = snd_ptr_q;
		ack_ptr_d = ack_ptr_q;
		full_d    = full_q;
		empty_d   = empty_q;
		vld_d     = vld_q;
		status_d  = ST_OK;
		fvalid_d  = 1'b0;
		fchar_d   = '0;
		snum_d    = '0;
		anum_d    = '0;
		ram_we    = 1'b0;

		case (func_q)
			FN_ADD: begin
				if (full_q) begin
					status_d = ST_FULL;
				end else begin
					ram_we           = cmd.commit;
					vld_d[wr_ptr_q]  = 1'b1;
					wr_ptr_d         = wr_next;
					if (wr_next2 == ack_ptr_q) begin
						full_d = 1'b1;
					end
					empty_d = 1'b0;
				end
			end
			FN_FETCH: begin
				if (empty_q) begin
					status_d = ST_NOTHING;
				end else begin
					// Entries never written since reset or clear read as zero.
					fvalid_d  = 1'b1;
					fchar_d   = vld_q[snd_ptr_q] ? rd_data : 8'd0;
					snum_d    = snd_w[2:0];
					anum_d    = ack_w[2:0];
					snd_ptr_d = snd_next;
					if (snd_next == wr_ptr_q) begin
						empty_d = 1'b1;
					end
				end
			end
			FN_ACK: begin
				if (num_w == ack_w) begin
					ack_ptr_d = ack_next;
					full_d    = 1'b0;
				end else begin
					status_d = ST_DROPPED;
				end
			end
			FN_NAK: begin
				if (32'(num_q) < 32'(WINDOW)) begin
					snd_ptr_d = num_w[PW-1:0];
					empty_d   = (num_w[PW-1:0] == wr_ptr_q);
				end else begin
					status_d = ST_DROPPED;
				end
			end
			FN_CLEAR: begin
				wr_ptr_d  = '0;
				snd_ptr_d = '0;
				ack_ptr_d = '0;
				full_d    = 1'b0;
				empty_d   = 1'b1;
				vld_d     = '0;
			end
			default: begin
			end
		endcase
	end

	assign out_data = {empty_q, full_q, anum_q, snum_q, fchar_q};
	assign out_user = {fvalid_q, status_q};
endmodule

FILE: src/sliding_window_arq_sender_core.sv
// Top level of the go-back-N ARQ sender window.
//
// This block keeps the sender side of a go-back-N link: a ring of WINDOW
// character slots with a write pointer, a next-to-send pointer and an
// oldest-unacknowledged pointer. Each input beat carries one operation in
// s_tuser (add a character, fetch the next frame, ACK, NAK or clear) and
// produces exactly one result beat on the master side, in order. Each beat is
// accepted in the idle state and then executed in the execute state, because the
// character store is a RAM with a registered read port that is addressed by the
// send pointer. The result sits in an output register, so the next beat is
// accepted while the previous result still waits; execution stalls only while
// that register is still occupied. The full flag is set when the write pointer
// plus one meets the ack pointer, so the window holds WINDOW-1 unsent or
// unacknowledged characters at most. Sequence numbers on the bus are three bits
// wide; for a window above eight slots the reported numbers are the low three
// bits of the pointers. A clear operation returns the window to its reset state
// at once, with store entries tracked by per-slot valid bits so that a slot not
// written since reset or clear reads as zero.
module sliding_window_arq_sender_core #(
	parameter int unsigned WINDOW = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] data_char, [10:8] ack_number, [15:11] zero
	input  logic [swarq_pkg::InDataW-1:0]     s_tdata,
	// [2:0] func
	input  logic [swarq_pkg::InUserW-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] frame_char, [10:8] send_number, [13:11] acked_number,
	// [14] window_full, [15] send_empty
	output logic [swarq_pkg::OutDataW-1:0]    m_tdata,
	// [1:0] status, [2] frame_valid
	output logic [swarq_pkg::OutUserW-1:0]    m_tuser
);
	import swarq_pkg::*;

	ctrl_cmd_t cmd;

	// Sequencing of beats through accept and execute.
	swarq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// Pointers, flags, character store and the result register.
	swarq_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.out_data (m_tdata),
		.out_user (m_tuser)
	);
endmodule

FILE: src/swarq_checker.sv
// Port-level checks for the sender window and their binding to the top level.
module swarq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [swarq_pkg::OutDataW-1:0] m_tdata,
	input logic [swarq_pkg::OutUserW-1:0] m_tuser
);
	import swarq_pkg::*;

	// A result beat that is not taken holds until it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Without a frame, the frame fields are zero.
	a_no_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tdata[13:0] == 14'd0)
		else $error("frame fields not zero without a frame");

	// A delivered frame always reports success.
	a_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
		else $error("frame delivered with an error status");

	// A rejected add leaves the window full; a rejected fetch leaves nothing to send.
	a_reject_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] != ST_FULL || m_tdata[14])
			&& (m_tuser[1:0] != ST_NOTHING || m_tdata[15]))
		else $error("rejection status disagrees with window flags");
endmodule

bind sliding_window_arq_sender_core swarq_checker u_swarq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
